// File: hw/rtl/bmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmi_pkg
// shared constants for the batched 3x3 matrix inverse: element count and
// the word indices of the two products behind each adjugate cofactor
// ----------------------------------------------------------------------------
package bmi_pkg;

    localparam int unsigned NUM_ELEM = 9;
    localparam int unsigned MAT_DIM  = 3;

    // cofactor k = elem[PA[k]] * elem[PB[k]] - elem[PC[k]] * elem[PD[k]]
    localparam int unsigned COF_PA [NUM_ELEM] = '{4, 6, 3, 7, 0, 6, 1, 3, 0};
    localparam int unsigned COF_PB [NUM_ELEM] = '{8, 5, 7, 2, 8, 1, 5, 2, 4};
    localparam int unsigned COF_PC [NUM_ELEM] = '{7, 3, 4, 8, 2, 7, 2, 5, 1};
    localparam int unsigned COF_PD [NUM_ELEM] = '{5, 8, 6, 1, 6, 0, 4, 0, 3};

endpackage

// File: hw/rtl/batch_matrix3_inverse.sv
`timescale 1ns / 1ps
// throughput: one matrix per cycle while the output is not stalled; the restoring
// divider resolves one quotient bit per stage in nine parallel lanes, so its depth
// sets the latency
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (aresetn low, synchronous) clears every stage valid bit; data is not reset
// ----------------------------------------------------------------------------
// batch_matrix3_inverse
// streaming 3x3 inverse in signed fixed point: adjugate over determinant,
// truncated and saturated, singular flag on a zero determinant
// ----------------------------------------------------------------------------
module batch_matrix3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // elem_0 .. elem_8, ELEM_WIDTH bits each, from the lowest bit up, zero pad
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // res_0 .. res_8, ELEM_WIDTH bits each, from the lowest bit up, zero pad
    output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int N    = bmi_pkg::NUM_ELEM;
    localparam int D3   = bmi_pkg::MAT_DIM;
    localparam int TDW  = ((9*ELEM_WIDTH+7)/8)*8;
    localparam int PW   = 2*W;
    localparam int CFW  = 2*W + 1;
    localparam int PPW  = 2*W + 1;
    localparam int DETW = 3*W + 3;
    localparam int NW   = CFW + 2*F;
    localparam int XW   = (NW > DETW + W) ? NW : DETW + W;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic signed [W-1:0] elem [N];
    for (genvar i = 0; i < N; i++) begin : g_unpack
        assign elem[i] = $signed(s_tdata[i*W +: W]);
    end

    // stage 1: cofactor products
    logic signed [PW-1:0]   s1_pa_reg [N];
    logic signed [PW-1:0]   s1_pb_reg [N];
    logic signed [W-1:0]    s1_col_reg [D3];
    // stage 2: cofactors
    logic signed [CFW-1:0]  s2_cof_reg [N];
    logic signed [W-1:0]    s2_col_reg [D3];
    // stage 3: determinant partial products
    logic signed [PPW-1:0]  s3_plo_reg [D3];
    logic signed [PPW-1:0]  s3_phi_reg [D3];
    logic signed [CFW-1:0]  s3_cof_reg [N];
    // stage 4: determinant
    logic signed [DETW-1:0] s4_det_reg;
    logic signed [CFW-1:0]  s4_cof_reg [N];
    // stage 5: magnitudes and signs
    logic [DETW-1:0]        s5_dmag_reg;
    logic [CFW-1:0]         s5_cmag_reg [N];
    logic                   s5_neg_reg [N];
    logic                   s5_sing_reg;

    logic [D3+1:0]          vld_reg;
    logic [D3+1:0]          last_reg;

    // divider pipeline, index j holds the state entering divide step j
    logic [XW-1:0]          dv_rem_reg  [0:W][N];
    logic [W-1:0]           dv_q_reg    [0:W][N];
    logic                   dv_neg_reg  [0:W][N];
    logic                   dv_big_reg  [0:W][N];
    logic [DETW-1:0]        dv_dmag_reg [0:W];
    logic                   dv_sing_reg [0:W];
    logic                   dv_last_reg [0:W];
    logic                   dv_vld_reg  [0:W];

    logic [TDW-1:0]         out_data_reg, out_data_next;
    logic                   out_sing_reg;
    logic                   out_last_reg;
    logic                   out_vld_reg;

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[D3:0], s_tvalid};
            out_vld_reg <= dv_vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last_reg <= {last_reg[D3:0], s_tlast};
        end
    end

    // ---------------- stages 1 to 5, per cofactor ----------------
    for (genvar k = 0; k < N; k++) begin : g_cof
        logic signed [CFW-1:0] cof_next;
        assign cof_next = CFW'(s1_pa_reg[k]) - CFW'(s1_pb_reg[k]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                s1_pa_reg[k]  <= elem[bmi_pkg::COF_PA[k]] * elem[bmi_pkg::COF_PB[k]];
                s1_pb_reg[k]  <= elem[bmi_pkg::COF_PC[k]] * elem[bmi_pkg::COF_PD[k]];
                s2_cof_reg[k] <= cof_next;
                s3_cof_reg[k] <= s2_cof_reg[k];
                s4_cof_reg[k] <= s3_cof_reg[k];
                s5_cmag_reg[k] <= s4_cof_reg[k][CFW-1] ? CFW'(-s4_cof_reg[k])
                                                       : CFW'(s4_cof_reg[k]);
                s5_neg_reg[k]  <= s4_cof_reg[k][CFW-1] ^ s4_det_reg[DETW-1];
            end
        end
    end

    // determinant by expansion along the first column
    for (genvar c = 0; c < D3; c++) begin : g_col
        logic signed [W:0] cof_lo, cof_hi;
        assign cof_lo = $signed({1'b0, s2_cof_reg[c][W-1:0]});
        assign cof_hi = $signed(s2_cof_reg[c][CFW-1:W]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                s1_col_reg[c] <= elem[c];
                s2_col_reg[c] <= s1_col_reg[c];
                s3_plo_reg[c] <= PPW'(s2_col_reg[c] * cof_lo);
                s3_phi_reg[c] <= PPW'(s2_col_reg[c] * cof_hi);
            end
        end
    end

    logic signed [DETW-1:0] det_next;
    always_comb begin
        det_next = '0;
        for (int c = 0; c < D3; c++) begin
            det_next = det_next + (DETW'(s3_phi_reg[c]) <<< W) + DETW'(s3_plo_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_det_reg  <= det_next;
            s5_dmag_reg <= s4_det_reg[DETW-1] ? DETW'(-s4_det_reg) : DETW'(s4_det_reg);
            s5_sing_reg <= (s4_det_reg == '0);
        end
    end

    // ---------------- stage 6: overflow check, divider load ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= vld_reg[D3+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_dmag_reg[0] <= s5_dmag_reg;
            dv_sing_reg[0] <= s5_sing_reg;
            dv_last_reg[0] <= last_reg[D3+1];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_load
        logic [XW-1:0] num_x, lim_x;
        assign num_x = XW'(s5_cmag_reg[k]) << (2*F);
        assign lim_x = XW'(s5_dmag_reg) << W;

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[0][k] <= num_x;
                dv_q_reg[0][k]   <= '0;
                dv_neg_reg[0][k] <= s5_neg_reg[k];
                // quotient needs more than W bits: saturate
                dv_big_reg[0][k] <= (num_x >= lim_x);
            end
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    for (genvar j = 0; j < W; j++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_dmag_reg[j+1] <= dv_dmag_reg[j];
                dv_sing_reg[j+1] <= dv_sing_reg[j];
                dv_last_reg[j+1] <= dv_last_reg[j];
            end
        end

        for (genvar k = 0; k < N; k++) begin : g_lane
            logic [XW-1:0] dsh;
            logic          geq;
            logic [W-1:0]  q_next;
            assign dsh    = XW'(dv_dmag_reg[j]) << (W-1-j);
            assign geq    = (dv_rem_reg[j][k] >= dsh);
            assign q_next = dv_q_reg[j][k] | (W'(geq) << (W-1-j));

            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[j+1][k] <= geq ? dv_rem_reg[j][k] - dsh : dv_rem_reg[j][k];
                    dv_q_reg[j+1][k]   <= q_next;
                    dv_neg_reg[j+1][k] <= dv_neg_reg[j][k];
                    dv_big_reg[j+1][k] <= dv_big_reg[j][k];
                end
            end
        end
    end

    // ---------------- output: saturate, apply sign ----------------
    always_comb begin
        logic [W-1:0] lim;
        logic [W-1:0] sat;
        out_data_next = '0;
        for (int k = 0; k < N; k++) begin
            lim = dv_neg_reg[W][k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            sat = (dv_big_reg[W][k] || dv_q_reg[W][k] > lim) ? lim : dv_q_reg[W][k];
            if (dv_sing_reg[W]) begin
                out_data_next[k*W +: W] = '0;
            end else begin
                out_data_next[k*W +: W] = dv_neg_reg[W][k] ? W'(-sat) : sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
            out_sing_reg <= dv_sing_reg[W];
            out_last_reg <= dv_last_reg[W];
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sing_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_vld_reg;

    // ---------------- assertions ----------------
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("singular result with nonzero data");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_reg) && $stable(out_data_reg))
        else $error("pipeline moved during stall");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for batch_matrix3_inverse: streams 3x3 Q16.16 matrices,
// predicts adjugate over determinant on wide integers, and checks each
// response in order, with and without random source and sink stalls
// ----------------------------------------------------------------------------
module tb;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int DW = ((9*EW+7)/8)*8;
    localparam logic [EW-1:0] ONE  = 32'h0001_0000;
    localparam logic [EW-1:0] EMAX = 32'h7fff_ffff;
    localparam logic [EW-1:0] EMIN = 32'h8000_0000;

    typedef struct packed {
        logic [8:0][EW-1:0] res;
        logic               singular;
        logic               last;
    } inverse_t;

    typedef struct {
        logic [8:0][EW-1:0] elem;
        logic               last;
        bit                 typed;
        inverse_t           want;
    } row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tlast = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] m_tdata;
    logic          m_tuser;
    logic          m_tlast;
    logic          m_tvalid;
    logic          m_tready = 1'b0;

    inverse_t pending_inverses[$];
    int       src_idle = 0;
    int       snk_idle = 0;
    int       errors = 0;

    batch_matrix3_inverse uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // exact adjugate over determinant, truncated and saturated
    function automatic inverse_t invert(logic [8:0][EW-1:0] m, logic lst);
        logic signed [127:0] e [9];
        logic signed [127:0] det, cof, q;
        inverse_t r;
        for (int k = 0; k < 9; k++) e[k] = 128'(signed'(m[k]));
        det = e[0]*e[4]*e[8] + e[3]*e[7]*e[2] + e[6]*e[1]*e[5]
            - e[6]*e[4]*e[2] - e[3]*e[1]*e[8] - e[0]*e[7]*e[5];
        r.singular = (det == 0);
        r.last = lst;
        for (int k = 0; k < 9; k++) begin
            if (r.singular) begin
                r.res[k] = '0;
            end else begin
                cof = e[bmi_pkg::COF_PA[k]]*e[bmi_pkg::COF_PB[k]]
                    - e[bmi_pkg::COF_PC[k]]*e[bmi_pkg::COF_PD[k]];
                q = (cof <<< (2*FB)) / det;
                if (q > 128'sh7fff_ffff) r.res[k] = EMAX;
                else if (q < -128'sh8000_0000) r.res[k] = EMIN;
                else r.res[k] = q[EW-1:0];
            end
        end
        return r;
    endfunction

    task automatic send_matrix(logic [8:0][EW-1:0] m, logic lst, bit typed, inverse_t want);
        bit rdy;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        s_tlast  <= lst;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        pending_inverses.insert(pending_inverses.size(), typed ? want : invert(m, lst));
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_inverses.size() == 0) begin
                $display("%0t: unexpected response tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                inverse_t w;
                w = pending_inverses.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_tdata[k*EW +: EW] !== w.res[k]) begin
                        $display("%0t: res_%0d expected %h actual %h",
                                 $time, k, w.res[k], m_tdata[k*EW +: EW]);
                        errors++;
                    end
                if (m_tuser !== w.singular) begin
                    $display("%0t: singular expected %b actual %b", $time, w.singular, m_tuser);
                    errors++;
                end
                if (m_tlast !== w.last) begin
                    $display("%0t: last expected %b actual %b", $time, w.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic row_t mk(logic [8:0][EW-1:0] m, logic lst);
        row_t r;
        r.elem = m; r.last = lst; r.typed = 1'b0; r.want = '0;
        return r;
    endfunction

    function automatic row_t mk_typed(logic [8:0][EW-1:0] m, logic lst, logic [EW-1:0] diag,
                                      logic sing);
        row_t r;
        r = mk(m, lst);
        r.typed = 1'b1;
        r.want.singular = sing;
        r.want.last = lst;
        r.want.res[0] = diag; r.want.res[4] = diag; r.want.res[8] = diag;
        return r;
    endfunction

    function automatic logic [EW-1:0] small_q();
        return EW'($signed($urandom_range(16*65536)) - 8*65536);
    endfunction

    function automatic logic [8:0][EW-1:0] rand_matrix();
        logic [8:0][EW-1:0] m;
        int kind;
        int src;
        kind = $urandom_range(9);
        for (int k = 0; k < 9; k++) begin
            case (kind)
                0, 1:    m[k] = $urandom();
                2:       m[k] = $urandom_range(1) ? ($urandom_range(1) ? EMAX : EMIN)
                                                  : $urandom();
                3:       m[k] = EW'($signed($urandom_range(6)) - 3);
                default: m[k] = small_q();
            endcase
        end
        // duplicate a column to force a zero determinant now and then
        src = 3 * int'($urandom_range(1));
        if ($urandom_range(7) == 0)
            for (int r = 0; r < 3; r++) m[r+6] = m[r+src];
        return m;
    endfunction

    row_t directed[$];

    function automatic void add_row(row_t r);
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        logic [8:0][EW-1:0] z;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        z = '0;
        add_row(mk_typed(z, 1'b0, '0, 1'b1));
        add_row(mk_typed({9{EMAX}}, 1'b1, '0, 1'b1));
        add_row(mk_typed({9{EMIN}}, 1'b0, '0, 1'b1));
        add_row(mk_typed({ONE, z[0], z[0], z[0], ONE, z[0], z[0], z[0], ONE},
                         1'b1, ONE, 1'b0));
        add_row(mk_typed({ONE<<1, z[0], z[0], z[0], ONE<<1, z[0], z[0], z[0], ONE<<1},
                         1'b0, 32'h0000_8000, 1'b0));
        // tiny determinant saturates high, then low
        add_row(mk({32'd1, z[0], z[0], z[0], 32'd1, z[0], z[0], z[0], 32'd1}, 1'b0));
        add_row(mk({-32'sd1, z[0], z[0], z[0], 32'd1, z[0], z[0], z[0], 32'd1}, 1'b1));
        add_row(mk({EMIN, z[0], z[0], z[0], EMIN, z[0], z[0], z[0], EMIN}, 1'b0));
        add_row(mk({EMAX, z[0], z[0], z[0], EMAX, z[0], z[0], z[0], EMAX}, 1'b0));
        add_row(mk({EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMAX}, 1'b1));
        add_row(mk({z[0], z[0], ONE, z[0], ONE, z[0], ONE, z[0], z[0]}, 1'b0));
        add_row(mk({32'h0003_0000, ONE, 32'hfffe_0000, z[0], 32'h0002_0000, ONE,
                    32'h0000_8000, 32'hffff_0000, 32'h0004_0000}, 1'b1));
        add_row(mk({9{32'hffff_ffff}}, 1'b0));
        add_row(mk({32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'h0,
                    32'h0, 32'hffff_ffff}, 1'b1));
        for (int k = 0; k < 6; k++) add_row(mk(rand_matrix(), 1'($urandom_range(1))));

        src_idle = 37; snk_idle = 75;
        foreach (directed[i])
            send_matrix(directed[i].elem, directed[i].last, directed[i].typed, directed[i].want);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 37 : (ph == 1) ? 75 : 0;
            snk_idle = (ph == 0) ? 75 : (ph == 1) ? 37 : 0;
            for (int n = 0; n < 650; n++)
                send_matrix(rand_matrix(), 1'($urandom_range(1)), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        snk_idle = 0;

        while (pending_inverses.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end
endmodule
